>>> hw/rtl/mft_pkg.sv
// types, codes and constants shared by the mac forwarding table modules
package mft_pkg;

  localparam int unsigned ENTRIES_DEF = 32;
  localparam int unsigned MAC_W       = 48;
  localparam int unsigned PORT_W      = 8;
  localparam int unsigned VLAN_W      = 12;
  localparam int unsigned TIME_W      = 16;
  localparam int unsigned REQ_W       = 3;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned OUT_IDX_W   = 5;

  localparam logic [TIME_W-1:0] AGE_LIMIT_RST = 16'd300;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_LOOKUP = 3'd0,
    REQ_INSERT = 3'd1,
    REQ_REMOVE = 3'd2,
    REQ_CLEAR  = 3'd3,
    REQ_AGE    = 3'd4
  } req_e_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_e_t;

  // control sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } state_t;

  // request token that walks down the row of cells
  typedef struct packed {
    logic              active;
    req_e_t            req;
    logic [MAC_W-1:0]  mac;
    logic [PORT_W-1:0] port;
    logic [VLAN_W-1:0] vlan;
    logic [TIME_W-1:0] now;
    logic              hit;
    logic              free;
    logic [PORT_W-1:0] hit_port;
    logic [VLAN_W-1:0] hit_vlan;
  } token_t;

  // entry write broadcast to all cells at the end of an insert
  typedef struct packed {
    logic              en;
    logic [MAC_W-1:0]  mac;
    logic [PORT_W-1:0] port;
    logic [VLAN_W-1:0] vlan;
    logic [TIME_W-1:0] now;
  } wr_t;

endpackage

>>> hw/rtl/mft_cell.sv
// one table entry cell: holds an entry and processes the passing request token
module mft_cell
  import mft_pkg::*;
#(
  parameter int unsigned IDX_W = 5,
  parameter int unsigned INDEX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  token_t            tok_i,
  input  logic [IDX_W-1:0]  hidx_i,
  input  logic [IDX_W-1:0]  fidx_i,
  input  logic [TIME_W-1:0] age_limit_i,
  input  wr_t               wr_i,
  input  logic [IDX_W-1:0]  wr_idx_i,
  output token_t            tok_o,
  output logic [IDX_W-1:0]  hidx_o,
  output logic [IDX_W-1:0]  fidx_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic              valid_r, valid_nxt;
  logic [MAC_W-1:0]  mac_r;
  logic [PORT_W-1:0] port_r;
  logic [VLAN_W-1:0] vlan_r;
  logic [TIME_W-1:0] stamp_r;

  token_t            tok_r, tok_nxt;
  logic [IDX_W-1:0]  hidx_r, hidx_nxt;
  logic [IDX_W-1:0]  fidx_r, fidx_nxt;

  logic              match;
  logic [TIME_W-1:0] age;
  logic              wr_me;

  assign match = valid_r && (mac_r == tok_i.mac);
  assign age   = tok_i.now - stamp_r;
  assign wr_me = wr_i.en && (wr_idx_i == MY_IDX);

  // token update and valid bit
  always_comb begin
    tok_nxt   = tok_i;
    hidx_nxt  = hidx_i;
    fidx_nxt  = fidx_i;
    valid_nxt = valid_r;
    if (tok_i.active) begin
      unique case (tok_i.req)
        REQ_LOOKUP, REQ_INSERT, REQ_REMOVE: begin
          if (!tok_i.hit && match) begin
            tok_nxt.hit      = 1'b1;
            tok_nxt.hit_port = port_r;
            tok_nxt.hit_vlan = vlan_r;
            hidx_nxt         = MY_IDX;
            if (tok_i.req == REQ_REMOVE && port_r == tok_i.port) begin
              valid_nxt = 1'b0;
            end
          end
          if (tok_i.req == REQ_INSERT && !tok_i.free && !valid_r) begin
            tok_nxt.free = 1'b1;
            fidx_nxt     = MY_IDX;
          end
        end
        REQ_CLEAR: begin
          valid_nxt = 1'b0;
        end
        REQ_AGE: begin
          if (!tok_i.hit && valid_r && age >= age_limit_i) begin
            tok_nxt.hit = 1'b1;
            hidx_nxt    = MY_IDX;
            valid_nxt   = 1'b0;
          end
        end
        default: begin
          tok_nxt = tok_i;
        end
      endcase
    end
    // insert commit after the scan
    if (wr_me) begin
      valid_nxt = 1'b1;
    end
  end

  // control state and token
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  // token indexes
  always_ff @(posedge clk) begin
    hidx_r <= hidx_nxt;
    fidx_r <= fidx_nxt;
  end

  // entry contents
  always_ff @(posedge clk) begin
    if (wr_me) begin
      mac_r   <= wr_i.mac;
      port_r  <= wr_i.port;
      vlan_r  <= wr_i.vlan;
      stamp_r <= wr_i.now;
    end
  end

  assign tok_o  = tok_r;
  assign hidx_o = hidx_r;
  assign fidx_o = fidx_r;

endmodule

>>> hw/rtl/mac_forwarding_table.sv
// mac forwarding table top level: request sequencer and row of entry cells
//
// Usage:
//  - a request transfer happens at a clock edge with start high and busy low;
//    the in_ ports carry request type, mac, port, vlan and current time
//  - the request token walks the row of cells, one entry per cycle, lowest
//    index first; each cell marks the first match, the first free entry or
//    the first aged entry and applies remove, clear and age on the spot
//  - an insert writes its chosen entry as the token leaves the last cell
//  - the result is registered as the token leaves the last cell and shown for one
//    cycle, marked by out_valid; busy stays high up to and including that
//    cycle, so the time one request takes is set by the cell row length
//  - the receiver cannot stall: every result is taken in its strobe cycle
//  - cfg_age_limit_sec is written when cfg_valid is high (cfg_ready is always
//    high); write it only while busy is low
//  - reset clears every valid bit at once and sets the age limit to 300
//  - entry_index carries the low 5 bits of the entry number
module mac_forwarding_table
  import mft_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [REQ_W-1:0]     in_req_type,
  input  logic [MAC_W-1:0]     in_mac_addr,
  input  logic [PORT_W-1:0]    in_port_id,
  input  logic [VLAN_W-1:0]    in_vlan_id,
  input  logic [TIME_W-1:0]    in_now_sec,
  output logic                 out_valid,
  output logic [STATUS_W-1:0]  out_status,
  output logic                 out_hit,
  output logic [OUT_IDX_W-1:0] out_entry_index,
  output logic [PORT_W-1:0]    out_port_out,
  output logic [VLAN_W-1:0]    out_vlan_out,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [TIME_W-1:0]    cfg_age_limit_sec
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);

  state_t state_r, state_nxt;

  logic [TIME_W-1:0] age_limit_r;

  token_t           tok   [0:ENTRIES];
  logic [IDX_W-1:0] hidx  [0:ENTRIES];
  logic [IDX_W-1:0] fidx  [0:ENTRIES];

  wr_t              wr;
  logic [IDX_W-1:0] wr_idx;
  token_t           tok_end;
  logic             done;

  logic [STATUS_W-1:0] res_status;
  logic                res_hit;
  logic [IDX_W-1:0]    res_idx;
  logic [31:0]         res_idx_ext;
  logic [PORT_W-1:0]   res_port;
  logic [VLAN_W-1:0]   res_vlan;

  logic [STATUS_W-1:0]  status_r;
  logic                 hit_r;
  logic [OUT_IDX_W-1:0] idx_r;
  logic [PORT_W-1:0]    port_r;
  logic [VLAN_W-1:0]    vlan_r;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      age_limit_r <= AGE_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      age_limit_r <= cfg_age_limit_sec;
    end
  end

  // token injection at the head of the row
  always_comb begin
    tok[0].active   = start && !busy;
    tok[0].req      = req_e_t'(in_req_type);
    tok[0].mac      = in_mac_addr;
    tok[0].port     = in_port_id;
    tok[0].vlan     = in_vlan_id;
    tok[0].now      = in_now_sec;
    tok[0].hit      = 1'b0;
    tok[0].free     = 1'b0;
    tok[0].hit_port = '0;
    tok[0].hit_vlan = '0;
    hidx[0]         = '0;
    fidx[0]         = '0;
  end

  // row of entry cells
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    mft_cell #(
      .IDX_W (IDX_W),
      .INDEX (g)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .tok_i       (tok[g]),
      .hidx_i      (hidx[g]),
      .fidx_i      (fidx[g]),
      .age_limit_i (age_limit_r),
      .wr_i        (wr),
      .wr_idx_i    (wr_idx),
      .tok_o       (tok[g+1]),
      .hidx_o      (hidx[g+1]),
      .fidx_o      (fidx[g+1])
    );
  end

  assign tok_end = tok[ENTRIES];
  assign done    = (state_r == S_SCAN) && tok_end.active;

  // insert commit
  always_comb begin
    wr.en   = done && (tok_end.req == REQ_INSERT) && (tok_end.hit || tok_end.free);
    wr.mac  = tok_end.mac;
    wr.port = tok_end.port;
    wr.vlan = tok_end.vlan;
    wr.now  = tok_end.now;
    wr_idx  = tok_end.hit ? hidx[ENTRIES] : fidx[ENTRIES];
  end

  // result decode from the token leaving the row
  always_comb begin
    res_status = STAT_OK;
    res_hit    = 1'b0;
    res_idx    = '0;
    res_port   = '0;
    res_vlan   = '0;
    unique case (tok_end.req)
      REQ_LOOKUP: begin
        if (tok_end.hit) begin
          res_hit  = 1'b1;
          res_idx  = hidx[ENTRIES];
          res_port = tok_end.hit_port;
          res_vlan = tok_end.hit_vlan;
        end else begin
          res_status = STAT_NOT_FOUND;
        end
      end
      REQ_INSERT: begin
        if (tok_end.hit) begin
          res_hit = 1'b1;
          res_idx = hidx[ENTRIES];
        end else if (tok_end.free) begin
          res_idx = fidx[ENTRIES];
        end else begin
          res_status = STAT_FULL;
        end
      end
      REQ_REMOVE: begin
        if (tok_end.hit) begin
          res_hit = 1'b1;
          res_idx = hidx[ENTRIES];
        end else begin
          res_status = STAT_NOT_FOUND;
        end
      end
      REQ_AGE: begin
        if (tok_end.hit) begin
          res_hit = 1'b1;
          res_idx = hidx[ENTRIES];
        end
      end
      default: begin
        res_status = STAT_OK;
      end
    endcase
  end

  assign res_idx_ext = 32'(res_idx);

  // result register
  always_ff @(posedge clk) begin
    if (done) begin
      status_r <= res_status;
      hit_r    <= res_hit;
      idx_r    <= res_idx_ext[OUT_IDX_W-1:0];
      port_r   <= res_port;
      vlan_r   <= res_vlan;
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) begin
        state_nxt = S_SCAN;
      end
      S_SCAN: if (tok_end.active) begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequencer outputs
  always_comb begin
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        busy = 1'b0;
      end
      S_SCAN: begin
        busy = 1'b1;
      end
      S_RESP: begin
        out_valid = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  assign out_status      = status_r;
  assign out_hit         = hit_r;
  assign out_entry_index = idx_r;
  assign out_port_out    = port_r;
  assign out_vlan_out    = vlan_r;

  // checks
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid)
    else $error("request transfer did not make the block busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe longer than one cycle");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STAT_OK || out_status == STAT_NOT_FOUND ||
                   out_status == STAT_FULL))
    else $error("result status code out of range");

  a_commit_scan: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |=> out_valid)
    else $error("insert commit not followed by a result");

endmodule
